[hdl/hoid_pkg.sv]
// Shared types and constants for the handover ID slot table.
// No dependencies.
package hoid_pkg;

    localparam int RNTI_W = 17;
    localparam int ID_W   = 13;
    localparam int SLOT_W = 4;
    localparam int MODE_W = 3;
    localparam int DATA_W = 48;

    localparam logic signed [RNTI_W-1:0] RNTI_FREE = '1;
    localparam logic signed [ID_W-1:0]   ID_UNSET  = '1;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC = 3'd0,
        MODE_REL   = 3'd1,
        MODE_PAIR  = 3'd2,
        MODE_FIND  = 3'd3,
        MODE_SET   = 3'd4,
        MODE_GET   = 3'd5
    } t_mode;

    typedef struct packed {
        logic signed [RNTI_W-1:0] rnti;
        logic signed [ID_W-1:0]   src;
        logic signed [ID_W-1:0]   tgt;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

endpackage

[hdl/handover_id_slot_table.sv]
// Handover ID slot table: slot memory, sequential scan and request control.
// Depends on hoid_pkg.
//
// channel  dir  tdata (low bit up)                          tuser
// s_*      in   slot[3:0] rnti[20:4] src[33:21] tgt[46:34]  mode[2:0]
// m_*      out  slot[3:0] rnti[20:4] src[33:21] tgt[46:34]  found[0]
//
// One request at a time. Direct requests (release, set, get) read only their own slot;
// searches and allocate read one slot per cycle from the slot memory and stop at
// the first match or the last slot. A result waits in the output register while
// the next request is taken; a request finishing while that register is full
// and stalled holds in S_DONE. Reset frees every slot through per-slot valid bits.
module handover_id_slot_table
    import hoid_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [DATA_W-1:0] i_s_tdata,   // slot, rnti_key, source_key, target_key
    input  logic [MODE_W-1:0] i_s_tuser,   // mode
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [DATA_W-1:0] o_m_tdata,   // slot_out, rnti_out, source_out, target_out
    output logic [0:0]        o_m_tuser    // found
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IW-1:0] LAST = IW'(NUM_SLOTS - 1);

    t_state                r_state, n_state;
    logic [NUM_SLOTS-1:0]  r_valid;
    logic [IW-1:0]         r_idx, n_idx;
    logic                  r_more, n_more;
    logic                  r_cmp_vld, n_cmp_vld;
    logic [IW-1:0]         r_cmp_idx;
    t_mode                 r_mode;
    t_entry                r_key;
    logic                  r_res_found;
    logic [SLOT_W-1:0]     r_res_slot;
    t_entry                r_res;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_found;
    logic [SLOT_W-1:0]     r_out_slot;
    t_entry                r_out;
    t_entry                mem [NUM_SLOTS];
    t_entry                r_rd_data;
    logic                  r_rd_valid;

    logic                  accept;
    logic                  rd_en;
    logic                  finish;
    logic                  match;
    logic                  wr_en;
    logic                  is_write;
    logic                  in_range;
    logic                  direct;
    logic                  mode_ok;
    t_mode                 in_mode;
    logic [SLOT_W-1:0]     in_slot;
    t_entry                eff;
    t_entry                wr_data;
    logic                  load_out;

    assign in_mode  = t_mode'(i_s_tuser);
    assign in_slot  = i_s_tdata[3:0];
    assign in_range = 32'(in_slot) < NUM_SLOTS;
    assign accept   = i_s_tvalid && o_s_tready;
    assign rd_en    = (r_state == S_SCAN) && r_more;

    always_comb begin
        direct  = 1'b0;
        mode_ok = 1'b1;
        unique case (in_mode)
            MODE_ALLOC, MODE_PAIR, MODE_FIND: direct = 1'b0;
            MODE_REL, MODE_SET, MODE_GET:     direct = 1'b1;
            default:                          mode_ok = 1'b0;
        endcase
    end

    // Slot contents as seen through the valid bits
    always_comb begin
        eff.rnti = r_rd_valid ? r_rd_data.rnti : RNTI_FREE;
        eff.src  = r_rd_valid ? r_rd_data.src  : '0;
        eff.tgt  = r_rd_valid ? r_rd_data.tgt  : '0;
    end

    always_comb begin
        match    = 1'b1;
        is_write = 1'b0;
        wr_data  = r_key;
        unique case (r_mode)
            MODE_ALLOC: begin
                match        = (eff.rnti == RNTI_FREE);
                is_write     = 1'b1;
                wr_data.rnti = '0;
                wr_data.src  = ID_UNSET;
                wr_data.tgt  = ID_UNSET;
            end
            MODE_REL: begin
                is_write     = 1'b1;
                wr_data.rnti = RNTI_FREE;
                wr_data.src  = eff.src;
                wr_data.tgt  = eff.tgt;
            end
            MODE_PAIR: match = (eff.rnti != RNTI_FREE) && (eff.src == r_key.src)
                               && (eff.tgt == r_key.tgt);
            MODE_FIND: match = (eff.rnti == r_key.rnti);
            MODE_SET:  is_write = 1'b1;
            MODE_GET:  match = 1'b1;
            default:   match = 1'b1;
        endcase
    end

    assign finish   = (r_state == S_SCAN) && r_cmp_vld && (match || !r_more);
    assign wr_en    = finish && match && is_write;
    assign load_out = (r_state == S_DONE) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_more      = r_more;
        n_cmp_vld   = r_cmp_vld;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmp_vld = 1'b0;
                    n_more    = 1'b1;
                    n_idx     = direct ? IW'(in_slot) : '0;
                    if (!mode_ok || (direct && !in_range)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_cmp_vld = rd_en;
                if (rd_en) begin
                    n_idx  = r_idx + 1'b1;
                    n_more = !(r_mode == MODE_REL || r_mode == MODE_SET || r_mode == MODE_GET)
                             && (r_idx != LAST);
                end
                if (finish) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (load_out) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_more      <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_more      <= n_more;
            r_cmp_vld   <= n_cmp_vld;
            r_out_valid <= n_out_valid;
            if (wr_en) begin
                r_valid[r_cmp_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (rd_en) begin
            r_cmp_idx <= r_idx;
        end
        if (accept) begin
            r_mode      <= in_mode;
            r_key.rnti  <= i_s_tdata[20:4];
            r_key.src   <= i_s_tdata[33:21];
            r_key.tgt   <= i_s_tdata[46:34];
            r_res_found <= 1'b0;
            r_res_slot  <= '0;
            r_res       <= '0;
        end
        if (finish) begin
            r_res_found <= match;
            r_res_slot  <= match ? SLOT_W'(r_cmp_idx) : '0;
            if (!match) begin
                r_res <= '0;
            end else if (is_write) begin
                r_res <= wr_data;
            end else begin
                r_res <= eff;
            end
        end
        if (load_out) begin
            r_out_found <= r_res_found;
            r_out_slot  <= r_res_slot;
            r_out       <= r_res;
        end
    end

    // Slot memory, one read and one write port, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_cmp_idx] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data  <= mem[r_idx];
            r_rd_valid <= r_valid[r_idx];
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_found;
    assign o_m_tdata  = {1'b0, r_out.tgt, r_out.src, r_out.rnti, r_out_slot};

endmodule

[hdl/hoid_chk.sv]
// Port-level checks for the handover ID slot table, bound to the top level.
// Depends on hoid_pkg.
module hoid_chk
    import hoid_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_s_tvalid,
    input logic              o_s_tready,
    input logic [DATA_W-1:0] i_s_tdata,
    input logic [MODE_W-1:0] i_s_tuser,
    input logic              o_m_tvalid,
    input logic              i_m_tready,
    input logic [DATA_W-1:0] o_m_tdata,
    input logic [0:0]        o_m_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("result dropped while stalled");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata == '0))
        else $error("miss result carries nonzero fields");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request taken while another is in flight");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> ($stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("result changed while stalled");

endmodule

bind handover_id_slot_table hoid_chk u_hoid_chk (.*);
